>>> sv/i2c_mbe_pkg.sv
// Types, opcodes and slot counts shared by the I2C master bit engine.
`default_nettype none
package i2c_mbe_pkg;

  // Command codes carried in the opcode field
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } opcode_t;

  // Position inside a three-slot bit period
  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam logic [SLOT_W-1:0] READ_LAST_SLOT = SLOT_W'(24);

  // Sequencer state carried from one slot to the next
  typedef struct packed {
    opcode_t             cmd;
    logic [SLOT_W-1:0]   slot;
    phase_t              phase;
    logic [BYTE_W-1:0]   shift;
    logic                scl;
    logic                sda;
    logic [BYTE_W-1:0]   rbyte;
    logic                rack;
    logic                held_ack;
  } eng_state_t;

  // Number of slots each command occupies
  function automatic logic [SLOT_W:0] cmd_len(input opcode_t op);
    logic [SLOT_W:0] len;
    case (op)
      OP_START: len = (SLOT_W+1)'(4);
      OP_STOP:  len = (SLOT_W+1)'(3);
      OP_WRITE: len = (SLOT_W+1)'(24);
      OP_READ:  len = (SLOT_W+1)'(25);
      OP_SACK:  len = (SLOT_W+1)'(3);
      OP_RACK:  len = (SLOT_W+1)'(4);
      default:  len = '0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

>>> sv/i2c_mbe_slot.sv
// Next-state logic for one line slot of the I2C master bit engine.
`default_nettype none
module i2c_mbe_slot (
  input  i2c_mbe_pkg::eng_state_t cur,
  input  logic [2:0]              opcode,
  input  logic [7:0]              write_data,
  input  logic                    ack_value,
  input  logic                    sda_level,
  output i2c_mbe_pkg::eng_state_t nxt,
  output logic                    done
);
  import i2c_mbe_pkg::*;

  always_comb begin
    eng_state_t      st;
    logic [SLOT_W:0] slot_inc;
    phase_t          ph_adv;
    st = cur;
    done = 1'b0;
    slot_inc = '0;

    // Take a new command only while idle
    if (st.cmd == OP_NONE && opcode inside {[OP_START:OP_RACK]}) begin
      st.cmd      = opcode_t'(opcode);
      st.slot     = '0;
      st.phase    = PH_DATA;
      st.shift    = (opcode_t'(opcode) == OP_WRITE) ? write_data : '0;
      st.held_ack = ack_value;
    end

    // Advance the bit phase; read holds it through its release slot
    case (cur.phase)
      PH_DATA: ph_adv = PH_HIGH;
      PH_HIGH: ph_adv = PH_LOW;
      default: ph_adv = PH_DATA;
    endcase

    nxt = st;
    if (st.cmd != OP_NONE) begin
      // Drive or sample the lines for this slot
      case (st.cmd)
        OP_START: begin
          case (st.slot)
            SLOT_W'(0): nxt.sda = 1'b1;
            SLOT_W'(1): nxt.scl = 1'b1;
            SLOT_W'(2): nxt.sda = 1'b0;
            default:    nxt.scl = 1'b0;
          endcase
        end
        OP_STOP: begin
          case (st.slot)
            SLOT_W'(0): nxt.sda = 1'b0;
            SLOT_W'(1): nxt.scl = 1'b1;
            default:    nxt.sda = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (st.phase)
            PH_DATA: nxt.sda = st.shift[BYTE_W-1];
            PH_HIGH: nxt.scl = 1'b1;
            default: begin
              nxt.scl   = 1'b0;
              nxt.shift = {st.shift[BYTE_W-2:0], 1'b0};
            end
          endcase
        end
        OP_READ: begin
          if (st.slot == '0) begin
            nxt.sda = 1'b1;
          end else begin
            case (st.phase)
              PH_DATA: nxt.scl = 1'b1;
              PH_HIGH: nxt.shift = {st.shift[BYTE_W-2:0], sda_level};
              default: begin
                nxt.scl = 1'b0;
                if (st.slot == READ_LAST_SLOT) nxt.rbyte = st.shift;
              end
            endcase
          end
        end
        OP_SACK: begin
          case (st.slot)
            SLOT_W'(0): nxt.sda = st.held_ack;
            SLOT_W'(1): nxt.scl = 1'b1;
            default:    nxt.scl = 1'b0;
          endcase
        end
        OP_RACK: begin
          case (st.slot)
            SLOT_W'(0): nxt.sda = 1'b1;
            SLOT_W'(1): nxt.scl = 1'b1;
            SLOT_W'(2): nxt.rack = sda_level;
            default:    nxt.scl = 1'b0;
          endcase
        end
        default: ;
      endcase

      // Step the slot counter or finish the command
      if (st.cmd == OP_READ && st.slot == '0) begin
        nxt.phase = PH_DATA;
      end else if (st.slot == '0) begin
        nxt.phase = PH_HIGH;
      end else begin
        nxt.phase = ph_adv;
      end
      slot_inc = {1'b0, st.slot} + (SLOT_W+1)'(1);
      if (slot_inc >= cmd_len(st.cmd)) begin
        nxt.cmd   = OP_NONE;
        nxt.slot  = '0;
        nxt.phase = PH_DATA;
        done      = 1'b1;
      end else begin
        nxt.slot = slot_inc[SLOT_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: input register, state and result register.
`default_nettype none
// Each input beat is one line time slot and yields exactly one result beat
// with the SCL/SDA levels after that slot, busy, done, the last read byte and
// the last received ack. A command (start 4 slots, stop 3, write byte 24,
// read byte 25, send ack 3, receive ack 4) is taken only while idle; opcodes
// given while busy are ignored. One beat per clock is sustained while the sink
// accepts results: beats land in an input register, the slot logic updates the
// sequencer state from it and writes the result register, which a stalled sink
// holds while the input register keeps one more beat.
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] opcode, [10:3] write_data, [11] ack_value, [12] sda_level, [15:13] zero
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
  // [11:4] read_data, [12] ack_seen, [15:13] zero
  output logic [15:0] m_tdata
);
  import i2c_mbe_pkg::*;

  logic        in_valid;
  logic [2:0]  in_opcode;
  logic [7:0]  in_write_data;
  logic        in_ack_value;
  logic        in_sda_level;
  logic        fire;
  eng_state_t  state;
  eng_state_t  state_next;
  logic        slot_done;

  // Process the held beat when the result register can take it
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode     <= s_tdata[2:0];
      in_write_data <= s_tdata[10:3];
      in_ack_value  <= s_tdata[11];
      in_sda_level  <= s_tdata[12];
    end
  end

  i2c_mbe_slot u_slot (
    .cur        (state),
    .opcode     (in_opcode),
    .write_data (in_write_data),
    .ack_value  (in_ack_value),
    .sda_level  (in_sda_level),
    .nxt        (state_next),
    .done       (slot_done)
  );

  // Sequencer state advances once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state.cmd      <= OP_NONE;
      state.slot     <= '0;
      state.phase    <= PH_DATA;
      state.shift    <= '0;
      state.scl      <= 1'b1;
      state.sda      <= 1'b1;
      state.rbyte    <= '0;
      state.rack     <= 1'b1;
      state.held_ack <= 1'b0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, state_next.rack, state_next.rbyte, slot_done,
                  (state_next.cmd != OP_NONE), state_next.sda, state_next.scl};
    end
  end

endmodule
`default_nettype wire
